// ----- hw/rtl/crss_pkg.sv -----
// ----------------------------------------------------------------------------
// crss_pkg
// Types, codes and constants shared by the shadow call stack modules.
// ----------------------------------------------------------------------------
package crss_pkg;

  localparam int STACK_DEPTH_DEF = 64;

  // request operation codes
  localparam logic [1:0] OP_PUSH  = 2'd0;
  localparam logic [1:0] OP_RET   = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;
  localparam logic [1:0] OP_READ  = 2'd3;

  // call type codes
  localparam logic [2:0] TYPE_SUB  = 3'd0;
  localparam logic [2:0] TYPE_NMI  = 3'd1;
  localparam logic [2:0] TYPE_IRQ  = 3'd2;
  localparam logic [2:0] TYPE_FIRQ = 3'd3;
  localparam logic [2:0] TYPE_SWI  = 3'd4;
  localparam logic [2:0] TYPE_SWI2 = 3'd5;
  localparam logic [2:0] TYPE_SWI3 = 3'd6;

  typedef struct packed {
    logic [1:0]  opcode;
    logic [2:0]  call_type;
    logic [15:0] from_pc;
    logic [7:0]  inst_length;
    logic [15:0] to_pc;
    logic [15:0] return_pc;
    logic [5:0]  read_index;
  } in_t;

  typedef struct packed {
    logic [6:0]  depth;
    logic        matched;
    logic [6:0]  popped;
    logic        overflow;
    logic        entry_valid;
    logic [2:0]  entry_type;
    logic [15:0] entry_from_pc;
    logic [15:0] entry_to_pc;
    logic [7:0]  entry_inst_length;
  } out_t;

  // one stack entry as held in the RAM
  typedef struct packed {
    logic [2:0]  call_type;
    logic [15:0] from_pc;
    logic [7:0]  inst_length;
    logic [15:0] to_pc;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  // controller to datapath
  typedef struct packed {
    logic start;    // capture request, clear working result
    logic exec;     // run the operation's first step
    logic rd_take;  // take RAM read data for a read request
    logic srch;     // one step of the return search
    logic load;     // move working result to the output register
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic srch_done;
  } sts_t;

endpackage

// ----- hw/rtl/crss_ram.sv -----
// ----------------------------------------------------------------------------
// crss_ram
// Generic RAM: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module crss_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- hw/rtl/crss_ctrl.sv -----
// ----------------------------------------------------------------------------
// crss_ctrl
// Sequencer for the shadow call stack: request intake, operation steps and
// the output register handshake.
// ----------------------------------------------------------------------------
module crss_ctrl
  import crss_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_opcode,
  output logic       in_stall,
  output logic       out_valid,
  input  logic       out_stall,
  input  sts_t       sts,
  output cmd_t       cmd
);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_EXEC = 3'd1;
  localparam logic [2:0] ST_RDW  = 3'd2;
  localparam logic [2:0] ST_SRCH = 3'd3;
  localparam logic [2:0] ST_DONE = 3'd4;

  logic [2:0] state;
  logic [2:0] state_next;
  logic [1:0] op;
  logic       out_valid_next;

  assign in_stall = (state != ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.start  = 1'b1;
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        cmd.exec = 1'b1;
        unique case (op)
          OP_READ: state_next = ST_RDW;
          OP_RET:  state_next = ST_SRCH;
          default: state_next = ST_DONE;
        endcase
      end
      ST_RDW: begin
        cmd.rd_take = 1'b1;
        state_next  = ST_DONE;
      end
      ST_SRCH: begin
        cmd.srch = 1'b1;
        if (sts.srch_done) begin
          state_next = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.load) begin
      out_valid_next = 1'b1;
    end else if (!out_stall) begin
      out_valid_next = 1'b0;
    end else begin
      out_valid_next = out_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op <= in_opcode;
    end
  end

endmodule

// ----- hw/rtl/crss_dpath.sv -----
// ----------------------------------------------------------------------------
// crss_dpath
// Datapath: stack RAM, depth counter, return-address scan and result
// registers.
// ----------------------------------------------------------------------------
module crss_dpath
  import crss_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  in_t  in_req,
  input  cmd_t cmd,
  output sts_t sts,
  output out_t out_res
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int DW = $clog2(STACK_DEPTH + 1);
  localparam int XW = (DW > 7) ? DW : 7;
  localparam int CW = (DW > 6) ? DW : 6;
  localparam int IW = (AW > 6) ? AW : 6;

  in_t             req;
  out_t            res;
  out_t            res_ld;
  logic [DW-1:0]   count;
  logic [DW-1:0]   scan;
  logic [AW-1:0]   pend_e;
  logic            pend_vld;

  logic            we;
  logic [AW-1:0]   waddr;
  logic [AW-1:0]   raddr;
  entry_t          wentry;
  entry_t          rentry;

  logic            full;
  logic            rd_ok;
  logic [IW-1:0]   ridx_x;
  logic [DW-1:0]   scan_m1;
  logic [16:0]     sum;
  logic [16:0]     ret_x;
  logic            hit;
  logic [DW-1:0]   pop_cnt;
  logic [XW-1:0]   pop_x;
  logic [XW-1:0]   cnt_x;

  assign full    = (count == DW'(STACK_DEPTH));
  assign rd_ok   = (CW'(req.read_index) < CW'(count));
  assign ridx_x  = IW'(req.read_index);
  assign scan_m1 = scan - DW'(1);

  assign we     = cmd.exec && (req.opcode == OP_PUSH) && !full;
  assign waddr  = count[AW-1:0];
  assign raddr  = cmd.srch ? scan_m1[AW-1:0] : ridx_x[AW-1:0];
  assign wentry = '{call_type:   req.call_type,
                    from_pc:     req.from_pc,
                    inst_length: req.inst_length,
                    to_pc:       req.to_pc};

  crss_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (STACK_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wentry),
    .raddr (raddr),
    .rdata (rentry)
  );

  // expected return address, unwrapped; SWI2 also matches one past it
  assign sum   = {1'b0, rentry.from_pc} + {9'd0, rentry.inst_length};
  assign ret_x = {1'b0, req.return_pc};
  assign hit   = pend_vld &&
                 ((sum == ret_x) ||
                  ((rentry.call_type == TYPE_SWI2) && ((sum + 17'd1) == ret_x)));

  assign sts.srch_done = hit || (scan == '0);

  assign pop_cnt = count - DW'(pend_e);
  assign pop_x   = XW'(pop_cnt);
  assign cnt_x   = XW'(count);

  always_comb begin
    res_ld       = res;
    res_ld.depth = cnt_x[6:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      pend_vld <= 1'b0;
    end else begin
      if (cmd.exec) begin
        pend_vld <= 1'b0;
        unique case (req.opcode)
          OP_PUSH:  if (!full) count <= count + DW'(1);
          OP_CLEAR: count <= '0;
          default: ;
        endcase
      end
      if (cmd.srch) begin
        if (hit) begin
          count    <= DW'(pend_e);
          pend_vld <= 1'b0;
        end else if (scan != '0) begin
          pend_vld <= 1'b1;
        end else begin
          pend_vld <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      req <= in_req;
      res <= '0;
    end
    if (cmd.exec) begin
      scan <= count;
      unique case (req.opcode)
        OP_PUSH: res.overflow    <= full;
        OP_READ: res.entry_valid <= rd_ok;
        default: ;
      endcase
    end
    if (cmd.rd_take && res.entry_valid) begin
      res.entry_type        <= rentry.call_type;
      res.entry_from_pc     <= rentry.from_pc;
      res.entry_to_pc       <= rentry.to_pc;
      res.entry_inst_length <= rentry.inst_length;
    end
    if (cmd.srch) begin
      if (hit) begin
        res.matched <= 1'b1;
        res.popped  <= pop_x[6:0];
      end else if (scan != '0) begin
        scan   <= scan_m1;
        pend_e <= scan_m1[AW-1:0];
      end
    end
    if (cmd.load) begin
      out_res <= res_ld;
    end
  end

endmodule

// ----- hw/rtl/call_return_shadow_stack.sv -----
// ----------------------------------------------------------------------------
// call_return_shadow_stack
// Shadow call stack for a debugger: records calls, unwinds on returns.
// ----------------------------------------------------------------------------
// One request is worked on at a time; in_stall is high from the cycle after a
// request is taken until the result is in the output register, and a new
// request is taken while that result still waits on out_stall. Push and clear
// run in one exec step; read adds a step that takes the registered RAM read
// data. A return searches the stack from the top down, one entry per cycle
// through the stack RAM's single read port, and stops at the first entry whose
// from_pc + inst_length (17 bits, or one past it for SWI2) equals return_pc.
// With no match nothing is popped. The stack RAM is not cleared at reset; the
// depth counter is.
module call_return_shadow_stack
  import crss_pkg::*;
#(
  parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_stall,
  input  in_t  in_req,
  output logic out_valid,
  input  logic out_stall,
  output out_t out_res
);

  cmd_t cmd;
  sts_t sts;

  crss_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_opcode (in_req.opcode),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  crss_dpath #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dpath (
    .clk     (clk),
    .rst     (rst),
    .in_req  (in_req),
    .cmd     (cmd),
    .sts     (sts),
    .out_res (out_res)
  );

endmodule
